// ----- sv/dbs_pkg.sv -----
// Package for the descending binary search block: sizes, beat types,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package dbs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(STORE_DEPTH);

  // input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // register index decoded from paddr
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef struct packed {
    logic                     kind;
    logic [ADDR_W-1:0]        slot;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic write;      // store load beat
    logic init;       // latch key, set search window
    logic probe;      // issue memory read at midpoint
    logic step;       // narrow window after a miss compare
    logic emit_hit;
    logic emit_miss;
  } dbs_cmd_t;

  typedef struct packed {
    logic more;       // window not empty
    logic hit;        // probed entry equals key
  } dbs_status_t;

endpackage

`default_nettype wire

// ----- sv/dbs_ctrl.sv -----
// Controller FSM for the descending binary search block.
// Depends on dbs_pkg; drives dbs_datapath through dbs_cmd_t.
`default_nettype none

module dbs_ctrl
  import dbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        kind,
  input  wire dbs_status_t status,
  output dbs_cmd_t         cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_SEARCH) begin
            cmd.init  = 1'b1;
            state_nxt = ST_CHECK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status.more) begin
          cmd.probe = 1'b1;
          state_nxt = ST_READ;
        end else begin
          cmd.emit_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        if (status.hit) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hit || cmd.emit_miss) |=> !busy)
    else $error("search result without return to idle");

  a_search_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && kind == KIND_SEARCH) |=> busy)
    else $error("accepted search did not start");

  a_probe_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |=> (cmd.emit_hit || cmd.step))
    else $error("probe not followed by compare");

endmodule

`default_nettype wire

// ----- sv/dbs_datapath.sv -----
// Datapath for the descending binary search block: element store, search
// window, compare and result register. Depends on dbs_pkg.
`default_nettype none

module dbs_datapath
  import dbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dbs_cmd_t           cmd,
  input  wire in_item_t           item,
  input  wire logic [COUNT_W-1:0] count,
  output dbs_status_t             status,
  output logic                    out_strobe,
  output out_item_t               out_data
);

  logic signed [DATA_W-1:0] mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] key_r;
  logic [COUNT_W-1:0]       lo_r;
  logic [COUNT_W-1:0]       hx_r;     // exclusive upper bound
  logic [ADDR_W-1:0]        mid_r;
  logic [COUNT_W-1:0]       span_w;
  logic [COUNT_W-1:0]       mid_w;
  logic                     out_strobe_r;
  out_item_t                out_data_r;

  // mid = lo + (hi - lo) / 2 with hi = hx - 1
  assign span_w = hx_r - lo_r - COUNT_W'(1);
  assign mid_w  = lo_r + (span_w >> 1);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[item.slot] <= item.value;
    end
    if (cmd.probe) begin
      rd_data_r <= mem[mid_w[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      key_r <= item.value;
      lo_r  <= '0;
      hx_r  <= (count > DEPTH_COUNT) ? DEPTH_COUNT : count;
    end
    if (cmd.probe) begin
      mid_r <= mid_w[ADDR_W-1:0];
    end
    if (cmd.step) begin
      // descending order: greater key lies to the left
      if (rd_data_r < key_r) begin
        hx_r <= {1'b0, mid_r};
      end else begin
        lo_r <= {1'b0, mid_r} + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_hit | cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit || cmd.emit_miss) begin
      out_data_r.found    <= cmd.emit_hit;
      out_data_r.position <= cmd.emit_hit ? mid_r : '0;
    end
  end

  assign status.more = (lo_r < hx_r);
  assign status.hit  = (rd_data_r == key_r);
  assign out_strobe  = out_strobe_r;
  assign out_data    = out_data_r;

  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (lo_r < hx_r) && (mid_w < hx_r) && (mid_w >= lo_r))
    else $error("probe outside search window");

  a_window_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (lo_r <= hx_r) && ((hx_r - lo_r) < ($past(hx_r) - $past(lo_r))))
    else $error("search window did not shrink");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_miss |=> out_strobe && !out_data.found && (out_data.position == '0))
    else $error("miss result malformed");

endmodule

`default_nettype wire

// ----- sv/descending_binary_search.sv -----
// Descending binary search: top level with APB register, controller, datapath.
// Load: written to the store without leaving idle, no result. Search: each probe is a
// registered memory read, then a compare; at most 11 probes. A hit or a miss is
// strobed from the result register once the search ends. One item
// at a time; busy is high while a search runs. Results show for one cycle, no stall.
// Synchronous active-low reset clears element_count and control; the store is not cleared.
`default_nettype none

module descending_binary_search
  import dbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_data,
  output logic                    out_strobe,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [COUNT_W-1:0] count_r;
  logic               reg_sel;
  dbs_cmd_t           cmd;
  dbs_status_t        status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ELEMENT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      count_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W-COUNT_W){1'b0}}, count_r} : '0;

  dbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .kind   (in_data.kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dbs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .item       (in_data),
    .count      (count_r),
    .status     (status),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for descending_binary_search: loads and searches driven
// over the command port, element_count set over APB, results checked in order.
// Depends on dbs_pkg and the descending_binary_search RTL.
`default_nettype none

module tb_top
  import dbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 30;   // margin after the longest search
  localparam int TARGET_BEATS  = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_start = 1'b0;
  in_item_t  in_beat = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_data;

  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  descending_binary_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_start),
    .busy       (busy),
    .in_data    (in_beat),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state, updated as beats are accepted
  logic signed [DATA_W-1:0] store_shadow [STORE_DEPTH];
  logic [COUNT_W-1:0]       count_shadow = '0;
  out_item_t                search_results_q [$];
  out_item_t                want;
  int                       mismatches = 0;
  int                       beats_accepted = 0;
  logic                     beat_taken = 1'b0;

  // stimulus side
  in_item_t                 pending_q [$];
  logic signed [DATA_W-1:0] plan_store [STORE_DEPTH];
  int                       beats_planned = 0;
  int                       gap_left = 0;
  int                       calm_left = 0;
  int                       cycle_count = 0;

  function automatic out_item_t run_search(logic signed [DATA_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    out_item_t r;
    r  = '0;
    lo = 0;
    hi = ((count_shadow > DEPTH_COUNT) ? STORE_DEPTH : int'(count_shadow)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (store_shadow[mid] == key) begin
        r.found    = 1'b1;
        r.position = ADDR_W'(mid);
        return r;
      end
      // descending order: larger key lies to the left
      if (store_shadow[mid] < key) hi = mid - 1;
      else lo = mid + 1;
    end
    return r;
  endfunction

  // results first, then the accepted beat; a search never answers on its own edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (search_results_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d position=%0d",
                   $time, out_data.found, out_data.position);
          mismatches++;
        end else begin
          want = search_results_q.pop_front();
          if (out_data.found !== want.found || out_data.position !== want.position) begin
            $display({"%0t: result mismatch expected found=%0d position=%0d, ",
                      "got found=%0d position=%0d"},
                     $time, want.found, want.position, out_data.found, out_data.position);
            mismatches++;
          end
        end
      end
      if (in_start && !busy) begin
        beats_accepted++;
        if (in_beat.kind == KIND_LOAD) store_shadow[in_beat.slot] = in_beat.value;
        else search_results_q.push_back(run_search(in_beat.value));
      end
    end
    beat_taken <= rst_n && in_start && !busy;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: hold a beat until taken, then an optional gap before the next one
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_start <= 1'b0;
    end else if (in_start && !beat_taken) begin
      // beat still waiting
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_start <= 1'b0;
    end else if (pending_q.size() != 0) begin
      in_beat  <= pending_q.pop_front();
      in_start <= 1'b1;
      gap_left <= next_gap();
    end else begin
      in_start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  task automatic push_load(int slot, logic [DATA_W-1:0] v);
    in_item_t it;
    it.kind  = KIND_LOAD;
    it.slot  = ADDR_W'(slot);
    it.value = v;
    pending_q.push_back(it);
    plan_store[slot] = v;
    beats_planned++;
  endtask

  task automatic push_search(logic [DATA_W-1:0] key);
    in_item_t it;
    it.kind  = KIND_SEARCH;
    it.slot  = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
    it.value = key;
    pending_q.push_back(it);
    beats_planned++;
  endtask

  task automatic wait_idle();
    while (beats_accepted != beats_planned || search_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write element_count, then read it back
  task automatic set_count(int unsigned n);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'(4 * REG_ELEMENT_COUNT);
    cfg_pwdata  <= PDATA_W'(n);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    count_shadow = COUNT_W'(n);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== PDATA_W'(count_shadow)) begin
      $display("%0t: element_count readback expected %0d, got %0d",
               $time, count_shadow, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // descending run in slots 0..n-1, or random values if unsorted; step range picks dense, duplicate-heavy or sparse
  task automatic fill_prefix(int n, bit unsorted);
    longint unsigned maxstep;
    longint unsigned slack;
    longint          v;
    if (unsorted) begin
      for (int i = 0; i < n; i++) push_load(i, $urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       maxstep = 2;
        1:       maxstep = 1000;
        default: maxstep = 64'hFFFF_FFFF / n;
      endcase
      slack = 64'hFFFF_FFFF - maxstep * (n - 1);
      v = 64'sd2147483647 - longint'($urandom_range(0, 32'(slack)));
      for (int i = 0; i < n; i++) begin
        push_load(i, 32'(v));
        v = v - longint'($urandom_range(0, 32'(maxstep)));
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key(int span);
    logic [DATA_W-1:0] k;
    int                r;
    r = $urandom_range(0, 9);
    if (span == 0 || r == 7) return $urandom;
    k = plan_store[$urandom_range(0, span - 1)];
    case (r)
      6:       return ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
      8:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      9:       return ($urandom_range(0, 1) != 0) ? 32'h0 : -32'sd1;
      default: return k;
    endcase
  endfunction

  initial begin
    int n;
    int span;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty window: no probe at all
    set_count(0);
    push_search(32'h0);

    // extremes, duplicates, top slot
    push_load(0, 32'h7FFF_FFFF);
    push_load(1, 32'd100);
    push_load(2, 32'd100);
    push_load(3, 32'd100);
    push_load(4, -32'sd5);
    push_load(5, 32'h8000_0000);
    push_load(STORE_DEPTH - 1, 32'h0);
    wait_idle();
    set_count(1);
    push_search(32'h7FFF_FFFF);
    push_search(-32'sd1);
    wait_idle();
    set_count(6);
    push_search(32'h7FFF_FFFF);
    push_search(32'd100);
    push_search(-32'sd5);
    push_search(32'h8000_0000);
    push_search(32'h0);
    push_search(32'd101);
    push_search(-32'sd6);
    // break the order and search through it
    push_load(2, -32'sd100);
    push_search(32'd100);
    push_search(-32'sd100);

    // whole store written, then windows beyond and at the depth
    wait_idle();
    fill_prefix(STORE_DEPTH, 1'b0);
    wait_idle();
    set_count(2047);
    repeat (20) push_search(pick_key(STORE_DEPTH));
    wait_idle();
    set_count(STORE_DEPTH);
    repeat (20) push_search(pick_key(STORE_DEPTH));

    while (beats_planned < TARGET_BEATS) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = $urandom_range(STORE_DEPTH + 1, 2047);
        2:       n = STORE_DEPTH;
        3, 4:    n = $urandom_range(17, 160);
        5:       n = $urandom_range(161, STORE_DEPTH - 1);
        default: n = $urandom_range(1, 16);
      endcase
      span = (n > STORE_DEPTH) ? STORE_DEPTH : n;
      wait_idle();
      set_count(n);
      if (span > 0 && span <= 160 && $urandom_range(0, 3) != 0)
        fill_prefix(span, $urandom_range(0, 7) == 0);
      repeat ($urandom_range(8, 30)) begin
        if ($urandom_range(0, 9) == 0)
          push_load($urandom_range(0, STORE_DEPTH - 1), $urandom);
        else
          push_search(pick_key(span));
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
